[design/sia_pkg.sv]
package sia_pkg;

   localparam int Width = 32;
   localparam int Stages = Width;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_NEG = 3'd2,
      OP_MUL = 3'd3,
      OP_QUO = 3'd4,
      OP_MOD = 3'd5
   } op_type;

   // item travelling down the divider chain
   typedef struct packed {
      logic             valid;
      logic [2:0]       op;
      logic [Width-1:0] a;
      logic [Width-1:0] b;
      logic [Width-1:0] rem;
      logic [Width-1:0] quo;
      logic [Width-1:0] mb;
      logic [Width-1:0] fast;
      logic             differ;
   } lane_type;

endpackage

[design/sia_cell.sv]
module sia_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               stall,
   input  sia_pkg::lane_type  lane_in,
   output sia_pkg::lane_type  lane_out
);

   sia_pkg::lane_type lane_ff, step_in;
   logic [sia_pkg::Width:0] trial;
   logic [sia_pkg::Width:0] shifted;

   // one restoring divide step: shift in a dividend bit, try to subtract
   always_comb begin
      step_in = lane_in;
      shifted = {lane_in.rem, lane_in.quo[sia_pkg::Width-1]};
      trial = shifted - {1'b0, lane_in.mb};
      if (!trial[sia_pkg::Width]) begin
         step_in.rem = trial[sia_pkg::Width-1:0];
         step_in.quo = {lane_in.quo[sia_pkg::Width-2:0], 1'b1};
      end else begin
         step_in.rem = shifted[sia_pkg::Width-1:0];
         step_in.quo = {lane_in.quo[sia_pkg::Width-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (!stall) begin
         lane_ff <= step_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

[design/signed_integer_alu_muldiv.sv]
// path from item accepted to result shown: entry register,
// 32 divide cells with one restoring step each, then the output register
// throughput: one item per cycle; the whole chain advances while no result
// waits under rsp_stall, and req_stall is raised while one does
// reset: synchronous, clears the valid bit of every stage; no other state
module signed_integer_alu_muldiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic signed [sia_pkg::Width-1:0] req_operand_a,
   input  logic signed [sia_pkg::Width-1:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [sia_pkg::Width-1:0] rsp_value,
   output logic        rsp_divide_by_zero
);

   localparam int W = sia_pkg::Width;

   sia_pkg::lane_type lanes [sia_pkg::Stages+1];
   sia_pkg::lane_type head_ff, head_in;
   logic [W-1:0] ma, mb;
   logic advance;

   logic        out_valid_ff;
   logic [W-1:0] out_value_ff, out_value_in;
   logic        out_dz_ff, out_dz_in;

   assign advance = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // entry stage: simple ops and magnitudes
   always_comb begin
      ma = req_operand_a[W-1] ? W'(-req_operand_a) : req_operand_a;
      mb = req_operand_b[W-1] ? W'(-req_operand_b) : req_operand_b;
      head_in.valid = req_valid;
      head_in.op = req_op;
      head_in.a = req_operand_a;
      head_in.b = req_operand_b;
      head_in.rem = '0;
      head_in.quo = ma;
      head_in.mb = mb;
      head_in.differ = req_operand_a[W-1] ^ req_operand_b[W-1];
      case (req_op)
         sia_pkg::OP_ADD: head_in.fast = req_operand_a + req_operand_b;
         sia_pkg::OP_SUB: head_in.fast = req_operand_a - req_operand_b;
         sia_pkg::OP_NEG: head_in.fast = W'(-req_operand_a);
         sia_pkg::OP_MUL: head_in.fast = W'(req_operand_a * req_operand_b);
         default:         head_in.fast = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff <= head_in;
      end
   end

   assign lanes[0] = head_ff;

   // quo field carries the remaining dividend bits, shifted out msb first
   genvar i;
   generate
      for (i = 0; i < sia_pkg::Stages; i++) begin : g_cell
         sia_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .stall   (!advance),
            .lane_in (lanes[i]),
            .lane_out(lanes[i+1])
         );
      end
   endgenerate

   // floor correction and result select
   sia_pkg::lane_type t;
   logic [W-1:0] q, base, m;
   logic nz;
   always_comb begin
      t = lanes[sia_pkg::Stages];
      nz = t.rem != '0;
      q = t.quo;
      base = t.rem;
      if (t.differ) begin
         q = W'(-t.quo) - W'(nz);
         if (nz) begin
            base = t.mb - t.rem;
         end
      end
      // floor remainder takes the sign of the divisor
      m = t.b[W-1] ? W'(-base) : base;
      out_dz_in = 1'b0;
      case (t.op)
         sia_pkg::OP_QUO: begin
            out_value_in = (t.b == '0) ? '0 : q;
            out_dz_in = t.b == '0;
         end
         sia_pkg::OP_MOD: begin
            out_value_in = (t.b == '0) ? t.a : m;
            out_dz_in = t.b == '0;
         end
         default: out_value_in = t.fast;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= t.valid;
         out_value_ff <= out_value_in;
         out_dz_ff <= out_dz_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_divide_by_zero = out_dz_ff;

   // a waiting result holds the chain
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("chain advanced under stalled result");
   // divide error flag held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_divide_by_zero))
      else $error("flag changed under stall");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("result changed under stall");

endmodule

[dv/signed_integer_alu_muldiv_test.sv]
module signed_integer_alu_muldiv_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency = 33;
   localparam int CycleLimit = 200000;
   localparam int HoldOff = 120;
   localparam logic [2:0] OpUnused6 = 3'd6;
   localparam logic [2:0] OpUnused7 = 3'd7;
   localparam logic signed [31:0] MinVal = 32'sh8000_0000;
   localparam logic signed [31:0] MaxVal = 32'sh7fff_ffff;

   typedef struct {
      logic signed [31:0] value;
      logic               dz;
   } alu_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_op = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic rsp_divide_by_zero;

   alu_result_type expected_results[$];
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_off_asks = 0;
   int hold_off_done = 0;
   int hold_off_cycles = 0;

   signed_integer_alu_muldiv dut (.*);

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 1) reset <= 1'b0;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // floor division on two's-complement patterns, divisor nonzero
   function automatic logic [31:0] floor_quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] qm;
      logic [31:0] rm;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      qm = ma / mb;
      rm = ma % mb;
      q = qm;
      if (a[31] != b[31]) begin
         q = -qm;
         if (rm != 0) q = q - 1;
      end
      return q;
   endfunction

   function automatic alu_result_type alu_predict(logic [2:0] op, logic [31:0] a,
                                                  logic [31:0] b);
      alu_result_type r;
      r.value = '0;
      r.dz = 1'b0;
      case (op)
         sia_pkg::OP_ADD: r.value = a + b;
         sia_pkg::OP_SUB: r.value = a - b;
         sia_pkg::OP_NEG: r.value = -a;
         sia_pkg::OP_MUL: r.value = a * b;
         sia_pkg::OP_QUO: begin
            if (b == 0) r.dz = 1'b1;
            else r.value = floor_quotient(a, b);
         end
         sia_pkg::OP_MOD: begin
            if (b == 0) begin
               r.dz = 1'b1;
               r.value = a;
            end else begin
               r.value = a - floor_quotient(a, b) * b;
            end
         end
         default: r.value = '0;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // result checking
   always @(posedge clock) begin
      alu_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item");
         end else begin
            e = expected_results.pop_front();
            if (rsp_value !== e.value)
               report_mismatch($sformatf("value %0d, wanted %0d", rsp_value, e.value));
            if (rsp_divide_by_zero !== e.dz)
               report_mismatch($sformatf("divide_by_zero %b, wanted %b",
                                         rsp_divide_by_zero, e.dz));
         end
      end
   end

   // receiver stalling, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else if (hold_off_asks != hold_off_done) begin
         rsp_stall <= 1'b1;
         hold_off_done <= hold_off_asks;
         hold_off_cycles <= HoldOff - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // send one item, with random idling ahead of it
   task automatic send_item(logic [2:0] op, logic [31:0] a, logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(alu_predict(op, a, b));
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(7))
         0: return MinVal;
         1: return MaxVal;
         2: return 32'($signed($urandom_range(8)) - 4);
         3: return 32'($urandom_range(255));
         4: return -32'($urandom_range(255));
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_item(sia_pkg::OP_ADD, MaxVal, 32'sd1);
      send_item(sia_pkg::OP_ADD, MinVal, MinVal);
      send_item(sia_pkg::OP_SUB, MinVal, 32'sd1);
      send_item(sia_pkg::OP_SUB, 32'sd0, MinVal);
      send_item(sia_pkg::OP_NEG, MinVal, 32'sd5);
      send_item(sia_pkg::OP_NEG, 32'sd7, -32'sd1);
      send_item(sia_pkg::OP_MUL, MaxVal, MaxVal);
      send_item(sia_pkg::OP_MUL, MinVal, -32'sd1);
      send_item(sia_pkg::OP_MUL, -32'sd3, 32'sd7);
      send_item(sia_pkg::OP_QUO, 32'sd7, 32'sd2);
      send_item(sia_pkg::OP_QUO, -32'sd7, 32'sd2);
      send_item(sia_pkg::OP_QUO, 32'sd7, -32'sd2);
      send_item(sia_pkg::OP_QUO, -32'sd7, -32'sd2);
      send_item(sia_pkg::OP_QUO, MinVal, -32'sd1);
      send_item(sia_pkg::OP_QUO, 32'sd9, 32'sd0);
      send_item(sia_pkg::OP_MOD, -32'sd7, 32'sd2);
      send_item(sia_pkg::OP_MOD, 32'sd7, -32'sd2);
      send_item(sia_pkg::OP_MOD, MinVal, -32'sd1);
      send_item(sia_pkg::OP_MOD, -32'sd9, 32'sd0);
      send_item(sia_pkg::OP_MOD, MaxVal, MinVal);
      send_item(OpUnused6, MaxVal, MaxVal);
      send_item(OpUnused7, MinVal, -32'sd1);
      pause_sender();
   endtask

   task automatic test_random(int count, int idle, int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_item(3'($urandom_range(7)), random_operand(), random_operand());
      pause_sender();
   endtask

   // receiver holds off while the sender keeps offering, filling the pipe
   task automatic test_back_pressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_asks++;
      repeat (60) send_item(3'($urandom_range(5)), random_operand(), random_operand());
      pause_sender();
   endtask

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      test_directed();
      test_random(100, 0, 0);
      test_random(80, 46, 0);
      test_random(80, 0, 46);
      test_random(80, 8, 8);
      test_back_pressure();
      send_idle_pct = 0;
      stall_pct = 30;
      while (expected_results.size() != 0) @(posedge clock);
      stall_pct = 0;
      repeat (Latency + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
design/sia_pkg.sv
design/sia_cell.sv
design/signed_integer_alu_muldiv.sv
dv/signed_integer_alu_muldiv_test.sv
